/* hdl/pteu_pkg.sv */
`timescale 1ns / 1ps
// pteu_pkg: word types, stored entry layout and fixed constants of the particle table
// no dependencies

package pteu_pkg;

    // render emits at most this many words
    localparam int RESULT_CAP = 64;

    // divider sizes
    localparam int DIV_NUM_W = 40;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_Q_W   = 8;
    localparam int DIV_K_W   = 3;

    // item kinds
    localparam logic [1:0] MODE_ADD     = 2'd0;
    localparam logic [1:0] MODE_ADVANCE = 2'd1;
    localparam logic [1:0] MODE_RENDER  = 2'd2;
    localparam logic [1:0] MODE_CLEAR   = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [31:0]        life_span;
        logic [15:0]        point_size;
        logic [23:0]        color_rgb;
        logic [31:0]        step_time;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [23:0]        out_rgb;
        logic [7:0]         fade;
        logic [15:0]        shown_size;
        logic               has_particle;
        logic               accepted;
        logic [6:0]         particle_count;
        logic               last;
    } t_out_word;

    // one table entry as held in memory
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic [31:0]        left;
        logic [31:0]        full;
        logic [15:0]        size;
        logic [23:0]        rgb;
    } t_entry;

endpackage

/* hdl/pteu_in_if.sv */
`timescale 1ns / 1ps
// pteu_in_if: valid/ready channel carrying one input word
// depends on pteu_pkg

interface pteu_in_if
    import pteu_pkg::*;
;
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/pteu_out_if.sv */
`timescale 1ns / 1ps
// pteu_out_if: valid/ready channel carrying one result word
// depends on pteu_pkg

interface pteu_out_if
    import pteu_pkg::*;
;
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/pteu_div.sv */
`timescale 1ns / 1ps
// pteu_div: restoring divider, one quotient bit per cycle
// depends on pteu_pkg

module pteu_div
    import pteu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    input  logic [DIV_K_W-1:0]   i_top_bit,
    output logic                 o_done,
    output logic [DIV_Q_W-1:0]   o_quot
);
    localparam int SH_W = DIV_DEN_W + DIV_Q_W;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_K_W-1:0]   r_k, n_k;
    logic [DIV_NUM_W-1:0] r_rem, n_rem;
    logic [DIV_Q_W-1:0]   r_q, n_q;
    logic [DIV_DEN_W-1:0] r_den, n_den;
    logic [SH_W-1:0]      w_shift;

    // trial subtrahend for the current bit
    assign w_shift = SH_W'(r_den) << r_k;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_k    = r_k;
        n_rem  = r_rem;
        n_q    = r_q;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_k    = i_top_bit;
            n_rem  = i_num;
            n_q    = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            if (SH_W'(r_rem) >= w_shift) begin
                n_rem    = r_rem - DIV_NUM_W'(w_shift);
                n_q[r_k] = 1'b1;
            end
            if (r_k == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_k = r_k - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_k   <= n_k;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

/* hdl/pteu_euler.sv */
`timescale 1ns / 1ps
// pteu_euler: per-axis velocity times step product register, then add with saturation
// depends on pteu_pkg

module pteu_euler
    import pteu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_load,
    input  logic [31:0]        i_dt,
    input  t_entry             i_ent_rd,
    input  t_entry             i_ent_hold,
    output logic signed [31:0] o_x,
    output logic signed [31:0] o_y,
    output logic signed [31:0] o_z
);
    logic signed [64:0] r_px, r_py, r_pz;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] pos,
                                                   input logic signed [64:0] prod);
        logic signed [48:0] q;
        logic signed [49:0] s;
        begin
            // arithmetic shift rounds toward minus infinity
            q = 49'(prod >>> 16);
            s = 50'(pos) + 50'(q);
            if (s > 50'sd2147483647)
                sat_add = 32'sh7fffffff;
            else if (s < -50'sd2147483648)
                sat_add = 32'sh80000000;
            else
                sat_add = s[31:0];
        end
    endfunction

    // products of the entry just read
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_px <= i_ent_rd.vx * $signed({1'b0, i_dt});
            r_py <= i_ent_rd.vy * $signed({1'b0, i_dt});
            r_pz <= i_ent_rd.vz * $signed({1'b0, i_dt});
        end
    end

    assign o_x = sat_add(i_ent_hold.x, r_px);
    assign o_y = sat_add(i_ent_hold.y, r_py);
    assign o_z = sat_add(i_ent_hold.z, r_pz);
endmodule

/* hdl/particle_table_euler_update.sv */
`timescale 1ns / 1ps
// particle_table_euler_update: particle table top level, entry memory and sequencer
// depends on pteu_pkg, pteu_in_if, pteu_out_if, pteu_div, pteu_euler

// Particle table with add, advance, render and clear words. All entries sit in one
// memory with one write port and a registered read; the sequencer takes one input word
// at a time. Add, clear and render of an empty table go from acceptance straight to
// the output word. Advance steps each live entry through read, product register, add
// and compacting write-back. Render steps each emitted word through the read, the entry
// load, the bit-serial fade divider with its result register, the size multiply, the
// scaling by 1/255 and the output load; an entry with zero full lifetime skips the
// divider. Output backpressure adds wait cycles at each word.

module particle_table_euler_update
    import pteu_pkg::*;
#(
    parameter int MAX_PARTICLES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pteu_in_if.sink     i_in,
    pteu_out_if.source  o_out
);
    localparam int CW = $clog2(MAX_PARTICLES + 1);
    localparam int IW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_ADV_RD    = 4'd1;
    localparam logic [3:0] S_ADV_MUL   = 4'd2;
    localparam logic [3:0] S_ADV_WR    = 4'd3;
    localparam logic [3:0] S_RND_RD    = 4'd4;
    localparam logic [3:0] S_RND_LOAD  = 4'd5;
    localparam logic [3:0] S_FADE_WAIT = 4'd6;
    localparam logic [3:0] S_SIZE_MUL  = 4'd7;
    localparam logic [3:0] S_SIZE_GO   = 4'd8;
    localparam logic [3:0] S_EMIT      = 4'd9;

    t_entry          mem [MAX_PARTICLES];
    t_entry          r_rd;
    t_entry          r_ent, n_ent;
    logic [3:0]      r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_wr, n_wr;
    logic [CW-1:0]   r_n, n_n;
    logic [31:0]     r_dt, n_dt;
    logic [7:0]      r_fade, n_fade;
    logic [15:0]     r_size, n_size;
    logic [23:0]     r_prod, n_prod;
    logic            r_has, n_has;
    logic            r_acc, n_acc;
    logic            r_last, n_last;
    logic            r_ov, n_ov;
    t_out_word       r_out, n_out;

    logic            w_we;
    logic [IW-1:0]   w_waddr;
    t_entry          w_wdata;
    t_entry          w_new;
    logic            w_alive;
    logic            w_slot_free;
    logic            w_div_start;
    logic [DIV_NUM_W-1:0] w_div_num;
    logic [DIV_DEN_W-1:0] w_div_den;
    logic [DIV_K_W-1:0]   w_div_top;
    logic            w_div_done;
    logic [DIV_Q_W-1:0]   w_div_q;
    logic signed [31:0]   w_nx, w_ny, w_nz;
    logic [CW-1:0]   w_idx_inc;
    logic [CW-1:0]   w_cap_n;
    logic [48:0]     w_size_rcp;
    logic [15:0]     w_size_q;

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_slot_free = !r_ov || o_out.ready;
    assign w_alive     = r_ent.left > r_dt;
    assign w_idx_inc   = r_idx + 1'b1;

    // render length is the live count capped to the output limit
    assign w_cap_n = ((CW + 7)'(r_count) > (CW + 7)'(RESULT_CAP)) ?
                     CW'(RESULT_CAP) : r_count;

    // faded size: product over 255 as a multiply by 2^32/255 rounded up
    assign w_size_rcp = (49'(r_prod) << 24) + (49'(r_prod) << 16) +
                        (49'(r_prod) << 8) + (49'(r_prod) << 1);
    assign w_size_q   = w_size_rcp[47:32];

    pteu_euler u_euler (
        .i_clk      (i_clk),
        .i_load     (r_state == S_ADV_MUL),
        .i_dt       (r_dt),
        .i_ent_rd   (r_rd),
        .i_ent_hold (r_ent),
        .o_x        (w_nx),
        .o_y        (w_ny),
        .o_z        (w_nz)
    );

    // divider for the fade ratio
    always_comb begin
        w_div_start = (r_state == S_RND_LOAD) && (r_rd.full != '0);
        w_div_num   = (DIV_NUM_W'(r_rd.left) << 8) - DIV_NUM_W'(r_rd.left);
        w_div_den   = r_rd.full;
        w_div_top   = DIV_K_W'(7);
    end

    pteu_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_num     (w_div_num),
        .i_den     (w_div_den),
        .i_top_bit (w_div_top),
        .o_done    (w_div_done),
        .o_quot    (w_div_q)
    );

    // surviving entry after one step
    always_comb begin
        w_new      = r_ent;
        w_new.x    = w_nx;
        w_new.y    = w_ny;
        w_new.z    = w_nz;
        w_new.left = r_ent.left - r_dt;
    end

    // memory write port: add at the tail, or compacting write-back
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_wr[IW-1:0];
        w_wdata = w_new;
        if (r_state == S_IDLE) begin
            w_waddr = r_count[IW-1:0];
            w_wdata = '{x: i_in.data.pos_x, y: i_in.data.pos_y, z: i_in.data.pos_z,
                        vx: i_in.data.vel_x, vy: i_in.data.vel_y, vz: i_in.data.vel_z,
                        left: i_in.data.life_span, full: i_in.data.life_span,
                        size: i_in.data.point_size, rgb: i_in.data.color_rgb};
            w_we    = i_in.valid && (i_in.data.mode == MODE_ADD) &&
                      (r_count < CW'(MAX_PARTICLES));
        end else if (r_state == S_ADV_WR) begin
            w_we = w_alive;
        end
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (w_we)
            mem[w_waddr] <= w_wdata;
        r_rd <= mem[r_idx[IW-1:0]];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        n_wr    = r_wr;
        n_n     = r_n;
        n_dt    = r_dt;
        n_ent   = r_ent;
        n_fade  = r_fade;
        n_size  = r_size;
        n_prod  = r_prod;
        n_has   = r_has;
        n_acc   = r_acc;
        n_last  = r_last;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_has  = 1'b0;
                    n_acc  = 1'b0;
                    n_last = 1'b1;
                    n_idx  = '0;
                    n_wr   = '0;
                    n_dt   = i_in.data.step_time;
                    n_n    = w_cap_n;
                    n_state = S_EMIT;
                    unique case (i_in.data.mode)
                        MODE_ADD: begin
                            if (r_count < CW'(MAX_PARTICLES)) begin
                                n_count = r_count + 1'b1;
                                n_acc   = 1'b1;
                            end
                        end
                        MODE_ADVANCE: begin
                            if (r_count != '0)
                                n_state = S_ADV_RD;
                        end
                        MODE_RENDER: begin
                            if (r_count != '0)
                                n_state = S_RND_RD;
                        end
                        MODE_CLEAR: n_count = '0;
                        default: ;
                    endcase
                end
            end
            S_ADV_RD:  n_state = S_ADV_MUL;
            S_ADV_MUL: begin
                n_ent   = r_rd;
                n_state = S_ADV_WR;
            end
            S_ADV_WR: begin
                n_wr  = w_alive ? r_wr + 1'b1 : r_wr;
                n_idx = w_idx_inc;
                if (w_idx_inc == r_count) begin
                    n_count = n_wr;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_ADV_RD;
                end
            end
            S_RND_RD: n_state = S_RND_LOAD;
            S_RND_LOAD: begin
                n_ent  = r_rd;
                n_fade = '0;
                n_state = (r_rd.full != '0) ? S_FADE_WAIT : S_SIZE_MUL;
            end
            S_FADE_WAIT: begin
                if (w_div_done) begin
                    n_fade  = w_div_q;
                    n_state = S_SIZE_MUL;
                end
            end
            S_SIZE_MUL: begin
                n_prod  = r_ent.size * r_fade;
                n_state = S_SIZE_GO;
            end
            S_SIZE_GO: begin
                n_size  = w_size_q;
                n_has   = 1'b1;
                n_last  = (w_idx_inc == r_n);
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = w_idx_inc;
                        n_state = S_RND_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output register
    always_comb begin
        n_ov  = r_ov;
        n_out = r_out;
        if (r_ov && o_out.ready)
            n_ov = 1'b0;
        if ((r_state == S_EMIT) && w_slot_free) begin
            n_ov                 = 1'b1;
            n_out.out_x          = r_has ? r_ent.x : '0;
            n_out.out_y          = r_has ? r_ent.y : '0;
            n_out.out_z          = r_has ? r_ent.z : '0;
            n_out.out_rgb        = r_has ? r_ent.rgb : '0;
            n_out.fade           = r_has ? r_fade : '0;
            n_out.shown_size     = r_has ? r_size : '0;
            n_out.has_particle   = r_has;
            n_out.accepted       = r_acc;
            n_out.particle_count = 7'(r_count);
            n_out.last           = r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
        r_idx  <= n_idx;
        r_wr   <= n_wr;
        r_n    <= n_n;
        r_dt   <= n_dt;
        r_ent  <= n_ent;
        r_fade <= n_fade;
        r_size <= n_size;
        r_prod <= n_prod;
        r_has  <= n_has;
        r_acc  <= n_acc;
        r_last <= n_last;
        r_out  <= n_out;
    end

    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_PARTICLES))
        else $error("live count above table size");

    a_compact_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADV_WR) |-> (r_wr <= r_idx))
        else $error("compaction write ahead of read");

    a_load_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == S_EMIT))
        else $error("output word loaded outside emit");

    a_div_result_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_FADE_WAIT))
        else $error("divider result with no consumer");
endmodule

/* tb/particle_table_euler_update_test.sv */
`timescale 1ns / 1ps
// particle_table_euler_update_test: self-checking bench for the particle table
// depends on pteu_pkg, pteu_in_if, pteu_out_if and the particle_table_euler_update rtl

module particle_table_euler_update_test;
    import pteu_pkg::*;

    localparam int NPART = 64;
    localparam longint CYCLE_LIMIT = 4000000;

    // shadow particle table and queue of expected words
    class particle_scoreboard;
        logic signed [31:0] px[NPART], py[NPART], pz[NPART];
        logic signed [31:0] vx[NPART], vy[NPART], vz[NPART];
        logic [31:0] left_q[NPART], full_q[NPART];
        logic [15:0] size_q[NPART];
        logic [23:0] rgb_q[NPART];
        int unsigned live;
        t_out_word pending[$];
        int errors;

        function new();
            live = 0;
            errors = 0;
        endfunction

        function t_out_word status_word(logic acc);
            t_out_word w;
            w = '0;
            w.accepted = acc;
            w.particle_count = live[6:0];
            w.last = 1'b1;
            return w;
        endfunction

        // euler position update, floor shift and saturation
        function logic signed [31:0] step_axis(logic signed [31:0] p, logic signed [31:0] v,
                                               logic [31:0] dt);
            longint prod, q, s;
            prod = longint'(v) * longint'({32'd0, dt});
            q = prod >>> 16;
            s = longint'(p) + q;
            if (s > 64'sd2147483647) s = 64'sd2147483647;
            if (s < -64'sd2147483648) s = -64'sd2147483648;
            return s[31:0];
        endfunction

        // note one accepted input word
        function void note_input(t_in_word iw);
            int unsigned w, n;
            longint unsigned fd, sz;
            t_out_word o;
            case (iw.mode)
                MODE_ADD: begin
                    if (live < NPART) begin
                        px[live] = iw.pos_x; py[live] = iw.pos_y; pz[live] = iw.pos_z;
                        vx[live] = iw.vel_x; vy[live] = iw.vel_y; vz[live] = iw.vel_z;
                        left_q[live] = iw.life_span; full_q[live] = iw.life_span;
                        size_q[live] = iw.point_size; rgb_q[live] = iw.color_rgb;
                        live++;
                        pending.push_back(status_word(1'b1));
                    end else begin
                        pending.push_back(status_word(1'b0));
                    end
                end
                MODE_ADVANCE: begin
                    w = 0;
                    for (int i = 0; i < live; i++) begin
                        if (left_q[i] > iw.step_time) begin
                            px[w] = step_axis(px[i], vx[i], iw.step_time);
                            py[w] = step_axis(py[i], vy[i], iw.step_time);
                            pz[w] = step_axis(pz[i], vz[i], iw.step_time);
                            vx[w] = vx[i]; vy[w] = vy[i]; vz[w] = vz[i];
                            left_q[w] = left_q[i] - iw.step_time;
                            full_q[w] = full_q[i];
                            size_q[w] = size_q[i]; rgb_q[w] = rgb_q[i];
                            w++;
                        end
                    end
                    live = w;
                    pending.push_back(status_word(1'b0));
                end
                MODE_CLEAR: begin
                    live = 0;
                    pending.push_back(status_word(1'b0));
                end
                default: begin
                    n = (live > RESULT_CAP) ? RESULT_CAP : live;
                    if (n == 0) pending.push_back(status_word(1'b0));
                    for (int i = 0; i < n; i++) begin
                        fd = 0;
                        if (full_q[i] != 0) begin
                            fd = (longint'({32'd0, left_q[i]}) * 255) / full_q[i];
                            if (fd > 255) fd = 255;
                        end
                        sz = (longint'({48'd0, size_q[i]}) * fd) / 255;
                        o = '0;
                        o.out_x = px[i]; o.out_y = py[i]; o.out_z = pz[i];
                        o.out_rgb = rgb_q[i];
                        o.fade = fd[7:0];
                        o.shown_size = sz[15:0];
                        o.has_particle = 1'b1;
                        o.particle_count = live[6:0];
                        o.last = (i + 1 == n);
                        pending.push_back(o);
                    end
                end
            endcase
        endfunction

        // compare one accepted result word with the oldest expectation
        function void check_result(t_out_word got);
            t_out_word exp_w;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word %h", got);
                return;
            end
            exp_w = pending.pop_front();
            if (got !== exp_w) begin
                errors++;
                if (errors <= 10) $display("mismatch exp %h got %h", exp_w, got);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    longint cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;

    pteu_in_if  in_ch();
    pteu_out_if out_ch();
    particle_scoreboard sb = new();

    particle_table_euler_update #(.MAX_PARTICLES(NPART)) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always #1 i_clk = ~i_clk;

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: random stalls, plus long hold-off when requested
    initial out_ch.ready = 1'b0;
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
    end

    // offer one word, idle at random first, wait for acceptance
    task automatic send_word(t_in_word iw);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= iw;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_input(iw);
        @(negedge i_clk);
    endtask

    // drop valid and wait for every expected word
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] edgy32();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_word make_add(logic [31:0] life);
        t_in_word w;
        w = '0;
        w.mode = MODE_ADD;
        w.pos_x = edgy32(); w.pos_y = edgy32(); w.pos_z = edgy32();
        w.vel_x = edgy32(); w.vel_y = edgy32(); w.vel_z = edgy32();
        w.life_span = life;
        w.point_size = 16'($urandom);
        w.color_rgb = 24'($urandom);
        w.step_time = $urandom;
        return w;
    endfunction

    function automatic t_in_word make_op(logic [1:0] m, logic [31:0] dt);
        t_in_word w;
        w = make_add($urandom);
        w.mode = m;
        w.step_time = dt;
        return w;
    endfunction

    // random word, mostly adds with small steps so the table lives long
    function automatic t_in_word rand_word();
        int r;
        r = $urandom_range(99);
        if (r < 60) return make_add($urandom_range(1, 3) == 1 ? $urandom
                                                               : $urandom_range(0, 20'hfffff));
        if (r < 80) return make_op(MODE_ADVANCE, $urandom_range(3) == 0 ? $urandom
                                                  : $urandom_range(0, 20'h1ffff));
        if (r < 97) return make_op(MODE_RENDER, $urandom);
        return make_op(MODE_CLEAR, $urandom);
    endfunction

    initial begin
        t_in_word w;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty render, extremes, zero lifetime, saturation, clear
        send_word(make_op(MODE_RENDER, 0));
        send_word(make_add(32'h0));
        send_word(make_add(32'hffff_ffff));
        w = make_add(32'h0001_0000);
        w.pos_x = 32'h7fff_0000; w.vel_x = 32'h7fff_ffff;
        w.pos_y = 32'h8000_0000; w.vel_y = 32'h8000_0000;
        w.point_size = 16'hffff; w.color_rgb = 24'hffffff;
        send_word(w);
        send_word(make_op(MODE_RENDER, 0));
        send_word(make_op(MODE_ADVANCE, 32'h0000_8000));
        send_word(make_op(MODE_RENDER, 0));
        send_word(make_op(MODE_ADVANCE, 32'hffff_ffff));
        send_word(make_op(MODE_RENDER, 0));
        // fill past capacity so adds get refused
        for (int i = 0; i < 66; i++) send_word(make_add($urandom));
        send_word(make_op(MODE_RENDER, 0));
        send_word(make_op(MODE_CLEAR, 0));
        send_word(make_op(MODE_RENDER, 0));
        drain();

        // random phases with varying idle mixes
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 62 : 29) : 0;
            recv_stall_pct = (ph == 2) ? 62 : ((ph == 3) ? 29 : 0);
            if (ph == 2) hold_cycles = 3000;
            for (int i = 0; i < 38; i++) send_word(rand_word());
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;

        drain();
        repeat (2000) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
